FILE: sv/ac3ss_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and lookup tables for the AC-3 / E-AC-3 syncframe splitter.
// No dependencies; imported by every module of the block.
package ac3ss_pkg;

   localparam logic [12:0] MAX_FRAME_BYTES = 13'd4096;
   localparam logic [12:0] HEADER_BYTES    = 13'd6;
   localparam logic [12:0] MIN_FRAME_BYTES = 13'd6;
   localparam logic [7:0]  SYNC_HI         = 8'h0B;
   localparam logic [7:0]  SYNC_LO         = 8'h77;
   localparam logic [5:0]  MAX_FRMSIZECOD  = 6'd37;
   localparam logic [4:0]  AC3_MAX_BSID    = 5'd8;
   localparam logic [4:0]  EAC3_MAX_BSID   = 5'd16;
   localparam logic [4:0]  MIN_EAC3_RESET  = 5'd11;
   localparam logic [1:0]  FSCOD_48K       = 2'd0;
   localparam logic [1:0]  FSCOD_44K       = 2'd1;
   localparam logic [1:0]  FSCOD_RESERVED  = 2'd3;
   localparam logic [1:0]  KIND_INDEP      = 2'd0;
   localparam logic [1:0]  KIND_DEP        = 2'd1;
   localparam logic [1:0]  KIND_CONVERT    = 2'd2;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_TRUNCATED   = 3'd1;
   localparam logic [2:0] ST_BAD_SYNC    = 3'd2;
   localparam logic [2:0] ST_RESERVED    = 3'd3;
   localparam logic [2:0] ST_UNSUPPORTED = 3'd4;
   localparam logic [2:0] ST_INVALID     = 3'd5;

   typedef struct packed {
      logic [7:0] stream_byte;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] frame_offset;
      logic [12:0] frame_bytes;
      logic [4:0]  frame_bsid;
      logic [1:0]  substream_kind;
      logic        starts_access_unit;
      logic        stream_done;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [12:0] frame_len;
   } hdr_result_type;

   function automatic logic [9:0] kbps_lookup(input logic [4:0] idx);
      logic [9:0] r;
      unique case (idx)
         5'd0:  r = 10'd32;
         5'd1:  r = 10'd40;
         5'd2:  r = 10'd48;
         5'd3:  r = 10'd56;
         5'd4:  r = 10'd64;
         5'd5:  r = 10'd80;
         5'd6:  r = 10'd96;
         5'd7:  r = 10'd112;
         5'd8:  r = 10'd128;
         5'd9:  r = 10'd160;
         5'd10: r = 10'd192;
         5'd11: r = 10'd224;
         5'd12: r = 10'd256;
         5'd13: r = 10'd320;
         5'd14: r = 10'd384;
         5'd15: r = 10'd448;
         5'd16: r = 10'd512;
         5'd17: r = 10'd576;
         5'd18: r = 10'd640;
         default: r = 10'd0;
      endcase
      return r;
   endfunction

   function automatic logic [10:0] words_44k_lookup(input logic [4:0] idx);
      logic [10:0] r;
      unique case (idx)
         5'd0:  r = 11'd69;
         5'd1:  r = 11'd87;
         5'd2:  r = 11'd104;
         5'd3:  r = 11'd121;
         5'd4:  r = 11'd139;
         5'd5:  r = 11'd174;
         5'd6:  r = 11'd208;
         5'd7:  r = 11'd243;
         5'd8:  r = 11'd278;
         5'd9:  r = 11'd348;
         5'd10: r = 11'd417;
         5'd11: r = 11'd487;
         5'd12: r = 11'd557;
         5'd13: r = 11'd696;
         5'd14: r = 11'd835;
         5'd15: r = 11'd975;
         5'd16: r = 11'd1114;
         5'd17: r = 11'd1253;
         5'd18: r = 11'd1393;
         default: r = 11'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: sv/ac3_syncframe_splitter_top.sv
`timescale 1ns / 1ps
// AC-3 / E-AC-3 syncframe splitter top level: request register, result register, csr.
// A record goes from the request register via ac3ss_frame_ctrl into the result register.
// Throughput: one byte per cycle, unless a record held on rsp_ waits for rsp_ready.
// Reset: synchronous; clears stream state and both valid bits, min_eac3_bsid resets to 11.
// Depends on ac3ss_pkg and ac3ss_frame_ctrl.
module ac3_syncframe_splitter_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ac3ss_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ac3ss_pkg::rsp_type  rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [4:0]          csr_data
);
   import ac3ss_pkg::*;

   logic       in_valid_ff;
   req_type    in_item_ff;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_rec_ff;
   logic [4:0] min_bsid_ff;
   logic       advance;
   logic       produce;
   rsp_type    record;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_rec_ff;

   ac3ss_frame_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .item          (in_item_ff),
      .min_eac3_bsid (min_bsid_ff),
      .produce       (produce),
      .record        (record)
   );

   always_comb begin
      priority if (advance && produce) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         min_bsid_ff  <= MIN_EAC3_RESET;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            min_bsid_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
      if (advance && produce) begin
         out_rec_ff <= record;
      end
   end

endmodule

FILE: sv/ac3ss_hdr_parse.sv
`timescale 1ns / 1ps
// Syncframe header check: sync word, bsid class, frame length from the six header bytes.
// Depends on ac3ss_pkg.
module ac3ss_hdr_parse (
   input  logic [47:0]                  header,
   input  logic [4:0]                   min_eac3_bsid,
   output ac3ss_pkg::hdr_result_type    result
);
   import ac3ss_pkg::*;

   logic [7:0]  b0, b1, b2, b3, b4, b5;
   logic [4:0]  bsid;
   logic [1:0]  fscod;
   logic [5:0]  code;
   logic [9:0]  rate;
   logic [10:0] words;
   logic [11:0] frmsiz_p1;
   logic [12:0] eac3_bytes;
   logic [12:0] ac3_bytes;
   logic        is_eac3;

   assign b0 = header[47:40];
   assign b1 = header[39:32];
   assign b2 = header[31:24];
   assign b3 = header[23:16];
   assign b4 = header[15:8];
   assign b5 = header[7:0];

   assign bsid  = b5[7:3];
   assign fscod = b4[7:6];
   assign code  = b4[5:0];
   assign rate  = kbps_lookup(code[5:1]);
   assign words = words_44k_lookup(code[5:1]);

   assign is_eac3    = (bsid >= min_eac3_bsid) && (bsid <= EAC3_MAX_BSID);
   assign frmsiz_p1  = {1'b0, b2[2:0], b3} + 12'd1;
   assign eac3_bytes = {frmsiz_p1, 1'b0};

   always_comb begin
      priority if (fscod == FSCOD_48K) begin
         ac3_bytes = {1'b0, rate, 2'b00};
      end else if (fscod == FSCOD_44K) begin
         ac3_bytes = {1'b0, words + {10'd0, code[0]}, 1'b0};
      end else begin
         ac3_bytes = {1'b0, rate, 2'b00} + {2'b00, rate, 1'b0};
      end
   end

   always_comb begin
      result.frame_len = 13'd0;
      priority if (b0 != SYNC_HI || b1 != SYNC_LO) begin
         result.status = ST_BAD_SYNC;
      end else if (is_eac3) begin
         if (eac3_bytes < MIN_FRAME_BYTES) begin
            result.status = ST_INVALID;
         end else if (eac3_bytes > MAX_FRAME_BYTES) begin
            result.status = ST_UNSUPPORTED;
         end else begin
            result.status    = ST_OK;
            result.frame_len = eac3_bytes;
         end
      end else if (bsid > AC3_MAX_BSID) begin
         result.status = ST_UNSUPPORTED;
      end else if (fscod == FSCOD_RESERVED || code > MAX_FRMSIZECOD) begin
         result.status = ST_RESERVED;
      end else if (ac3_bytes > MAX_FRAME_BYTES) begin
         result.status = ST_UNSUPPORTED;
      end else begin
         result.status    = ST_OK;
         result.frame_len = ac3_bytes;
      end
   end

endmodule

FILE: sv/ac3ss_frame_ctrl.sv
`timescale 1ns / 1ps
// Per-byte stream state: header capture, frame counting, error latch and record build.
// Depends on ac3ss_pkg and ac3ss_hdr_parse.
module ac3ss_frame_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  ac3ss_pkg::req_type   item,
   input  logic [4:0]           min_eac3_bsid,
   output logic                 produce,
   output ac3ss_pkg::rsp_type   record
);
   import ac3ss_pkg::*;

   logic [47:0] hdr_ff, hdr_in;
   logic [12:0] bif_ff, bif_in;
   logic [12:0] flen_ff, flen_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] start_ff, start_in;
   logic        seen_ff, seen_in;
   logic        dep_ff, dep_in;
   logic        err_ff, err_in;

   logic [47:0]    h_new;
   logic [12:0]    bif_next;
   logic [12:0]    len_now;
   logic [31:0]    start_now;
   logic [1:0]     kind;
   logic           dep_new;
   logic           at_hdr;
   logic           clear;
   hdr_result_type parse;

   assign h_new     = (bif_ff < HEADER_BYTES) ? {hdr_ff[39:0], item.stream_byte} : hdr_ff;
   assign bif_next  = bif_ff + 13'd1;
   assign start_now = (bif_ff == 13'd0) ? pos_ff : start_ff;
   assign at_hdr    = (bif_next == HEADER_BYTES);
   assign len_now   = at_hdr ? parse.frame_len : flen_ff;
   assign kind      = h_new[31:30];
   assign dep_new   = dep_ff || (!seen_ff && kind == KIND_DEP);

   ac3ss_hdr_parse u_parse (
      .header        (h_new),
      .min_eac3_bsid (min_eac3_bsid),
      .result        (parse)
   );

   always_comb begin
      hdr_in   = hdr_ff;
      bif_in   = bif_ff;
      flen_in  = flen_ff;
      pos_in   = pos_ff;
      start_in = start_ff;
      seen_in  = seen_ff;
      dep_in   = dep_ff;
      err_in   = err_ff;
      clear    = 1'b0;
      produce  = 1'b0;
      record   = '0;
      if (advance) begin
         pos_in = pos_ff + 32'd1;
         if (err_ff) begin
            if (item.end_of_stream) begin
               produce             = 1'b1;
               record.status       = hdr_ff[2:0];
               record.frame_offset = start_ff;
               record.stream_done  = 1'b1;
               clear               = 1'b1;
            end
         end else begin
            hdr_in   = h_new;
            bif_in   = bif_next;
            start_in = start_now;
            if (at_hdr) begin
               flen_in = parse.frame_len;
            end
            priority if (at_hdr && parse.status != ST_OK) begin
               produce               = 1'b1;
               record.status         = parse.status;
               record.frame_offset   = start_now;
               record.frame_bsid     = h_new[7:3];
               record.substream_kind = kind;
               record.stream_done    = item.end_of_stream;
               err_in                = 1'b1;
               hdr_in                = {45'd0, parse.status};
               clear                 = item.end_of_stream;
            end else if (bif_next >= HEADER_BYTES && bif_next == len_now) begin
               produce                   = 1'b1;
               record.status             = (item.end_of_stream && dep_new) ? ST_INVALID : ST_OK;
               record.frame_offset       = start_now;
               record.frame_bytes        = len_now;
               record.frame_bsid         = h_new[7:3];
               record.substream_kind     = kind;
               record.starts_access_unit = !seen_ff || kind == KIND_INDEP
                                           || kind == KIND_CONVERT;
               record.stream_done        = item.end_of_stream;
               dep_in                    = dep_new;
               seen_in                   = 1'b1;
               bif_in                    = 13'd0;
               clear                     = item.end_of_stream;
            end else if (item.end_of_stream) begin
               produce             = 1'b1;
               record.status       = ST_TRUNCATED;
               record.frame_offset = start_now;
               record.stream_done  = 1'b1;
               clear               = 1'b1;
            end else begin
               produce = 1'b0;
            end
         end
         if (clear) begin
            hdr_in   = '0;
            bif_in   = '0;
            flen_in  = '0;
            pos_in   = '0;
            start_in = '0;
            seen_in  = 1'b0;
            dep_in   = 1'b0;
            err_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff   <= '0;
         bif_ff   <= '0;
         flen_ff  <= '0;
         pos_ff   <= '0;
         start_ff <= '0;
         seen_ff  <= 1'b0;
         dep_ff   <= 1'b0;
         err_ff   <= 1'b0;
      end else begin
         hdr_ff   <= hdr_in;
         bif_ff   <= bif_in;
         flen_ff  <= flen_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         seen_ff  <= seen_in;
         dep_ff   <= dep_in;
         err_ff   <= err_in;
      end
   end

endmodule
